@@ rtl/hid_pkg.sv @@
// ----------------------------------------------------------------------------
// hid_pkg
// shared widths, constants and controller/datapath interface types for the
// hex grid id distance core
// ----------------------------------------------------------------------------
package hid_pkg;

    localparam int MAX_RADIUS_DEF = 127;

    localparam int RADIUS_W    = 7;
    localparam int ID_W        = 16;
    localparam int COORD_W     = 8;
    localparam int DIST_W      = 8;
    localparam int Q_W         = 9;
    localparam int HEIGHT_W    = 9;
    localparam int R_W         = 10;
    localparam int DIFF_W      = 10;
    localparam int NSQ_W       = 2 * RADIUS_W;
    localparam int COUNT_W     = 17;
    localparam int IN_TDATA_W  = 2 * ID_W;
    localparam int OUT_TDATA_W = DIST_W + 4 * COORD_W;

    typedef struct packed {
        logic capture;
        logic step;
        logic result_load;
    } hid_cmd_t;

    typedef struct packed {
        logic ids_ok;
        logic walk_done;
        logic out_free;
    } hid_sts_t;

endpackage

@@ rtl/hex_id_distance_core.sv @@
// ----------------------------------------------------------------------------
// hex_id_distance_core
// cube distance between two linear cell ids of a pointy-top hex grid
//
//   channel        dir  tdata                                  tuser
//   s_axis         in   [15:0] first_id, [31:16] second_id     -
//   m_axis         out  [7:0] hex_distance, [15:8] first_q,    [0] ids_valid
//                       [23:16] first_r, [31:24] second_q,
//                       [39:32] second_r
//   grid_radius    in   write enable + 7-bit data, no read-back
//
// ids in range: IDLE, CHECK, then WALK column by column until both ids are found
// (both walks run side by side from q = -N), then FINISH
// an id out of range: IDLE, CHECK, then FINISH with no walk
// the next transaction is taken while a result waits in the output register
// a stalled output holds the block in its last step until the result leaves
// reset clears the radius to 0 and empties the output register
// ----------------------------------------------------------------------------
module hex_id_distance_core
    import hid_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   grid_radius_we,
    input  logic [RADIUS_W-1:0]    grid_radius_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_id, second_id
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hex_distance, first_q, first_r, second_q, second_r
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // ids_valid
    output logic [0:0]             m_axis_tuser
);

    hid_cmd_t cmd;
    hid_sts_t sts;

    hid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hid_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .grid_radius_we    (grid_radius_we),
        .grid_radius_wdata (grid_radius_wdata),
        .in_data           (s_axis_tdata),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_data          (m_axis_tdata),
        .out_user          (m_axis_tuser[0])
    );

endmodule

@@ rtl/hid_walker.sv @@
// ----------------------------------------------------------------------------
// hid_walker
// column walk that turns one linear cell id into axial (q, r), one column a
// cycle while step is high
// ----------------------------------------------------------------------------
module hid_walker
    import hid_pkg::*;
(
    input  logic                      clk,
    input  logic [RADIUS_W-1:0]       radius,
    input  logic [ID_W-1:0]           id,
    input  logic                      init,
    input  logic                      step,
    output logic                      found,
    output logic signed [COORD_W-1:0] q,
    output logic signed [COORD_W-1:0] r
);

    logic signed [Q_W-1:0]  q_reg;
    logic signed [Q_W-1:0]  q_next;
    logic [ID_W-1:0]        rem_reg;
    logic [ID_W-1:0]        rem_next;
    logic                   q_neg;
    logic [HEIGHT_W-1:0]    q_abs;
    logic [HEIGHT_W-1:0]    height;
    logic [R_W-1:0]         r_full;

    assign q_neg  = q_reg[Q_W-1];
    assign q_abs  = q_neg ? HEIGHT_W'(-q_reg) : HEIGHT_W'(q_reg);
    assign height = HEIGHT_W'({radius, 1'b0}) + HEIGHT_W'(1) - q_abs;
    assign found  = rem_reg < ID_W'(height);

    // row offset inside the column, the column's lowest r added
    assign r_full = R_W'(rem_reg[HEIGHT_W-1:0])
                  + (q_neg ? R_W'(q_abs) : R_W'(0))
                  - R_W'(radius);

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        if (init)
        begin
            q_next   = -$signed(Q_W'(radius));
            rem_next = id;
        end
        else if (step && !found)
        begin
            q_next   = q_reg + Q_W'(1);
            rem_next = rem_reg - ID_W'(height);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign q = q_reg[COORD_W-1:0];
    assign r = r_full[COORD_W-1:0];

endmodule

@@ rtl/hid_datapath.sv @@
// ----------------------------------------------------------------------------
// hid_datapath
// radius register, cell count, id range check, two column walkers, distance
// and the output register
// ----------------------------------------------------------------------------
module hid_datapath
    import hid_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   grid_radius_we,
    input  logic [RADIUS_W-1:0]    grid_radius_wdata,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  hid_cmd_t               cmd,
    output hid_sts_t               sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_user
);

    logic [RADIUS_W-1:0]        grid_radius_reg;
    logic [RADIUS_W-1:0]        radius;
    logic [NSQ_W-1:0]           nsq;
    logic [COUNT_W-1:0]         count_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [ID_W-1:0]            first_id_reg;
    logic [ID_W-1:0]            second_id_reg;
    logic                       first_found;
    logic                       second_found;
    logic signed [COORD_W-1:0]  first_q;
    logic signed [COORD_W-1:0]  first_r;
    logic signed [COORD_W-1:0]  second_q;
    logic signed [COORD_W-1:0]  second_r;
    logic signed [DIFF_W-1:0]   dq;
    logic signed [DIFF_W-1:0]   dr;
    logic signed [DIFF_W-1:0]   ds;
    logic [DIFF_W-1:0]          dq_abs;
    logic [DIFF_W-1:0]          dr_abs;
    logic [DIFF_W-1:0]          ds_abs;
    logic [DIFF_W-1:0]          dist_max;
    logic [OUT_TDATA_W-1:0]     data_next;
    logic                       out_valid_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;
    logic                       out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_radius_reg <= '0;
        end
        else if (grid_radius_we)
        begin
            grid_radius_reg <= grid_radius_wdata;
        end
    end

    assign radius = (int'(grid_radius_reg) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS)
                                                         : grid_radius_reg;

    // 3n^2 + 3n + 1
    assign nsq        = radius * radius;
    assign count_next = COUNT_W'({nsq, 1'b0}) + COUNT_W'(nsq)
                      + COUNT_W'({radius, 1'b0}) + COUNT_W'(radius) + COUNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            count_reg     <= count_next;
            first_id_reg  <= in_data[ID_W-1:0];
            second_id_reg <= in_data[IN_TDATA_W-1:ID_W];
        end
    end

    hid_walker u_first_walker (
        .clk    (clk),
        .radius (radius),
        .id     (in_data[ID_W-1:0]),
        .init   (cmd.capture),
        .step   (cmd.step),
        .found  (first_found),
        .q      (first_q),
        .r      (first_r)
    );

    hid_walker u_second_walker (
        .clk    (clk),
        .radius (radius),
        .id     (in_data[IN_TDATA_W-1:ID_W]),
        .init   (cmd.capture),
        .step   (cmd.step),
        .found  (second_found),
        .q      (second_q),
        .r      (second_r)
    );

    assign sts.ids_ok    = (COUNT_W'(first_id_reg) < count_reg)
                        && (COUNT_W'(second_id_reg) < count_reg);
    assign sts.walk_done = first_found && second_found;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign dq       = DIFF_W'(first_q) - DIFF_W'(second_q);
    assign dr       = DIFF_W'(first_r) - DIFF_W'(second_r);
    assign ds       = dq + dr;
    assign dq_abs   = dq[DIFF_W-1] ? DIFF_W'(-dq) : DIFF_W'(dq);
    assign dr_abs   = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
    assign ds_abs   = ds[DIFF_W-1] ? DIFF_W'(-ds) : DIFF_W'(ds);

    always_comb
    begin
        dist_max = (dq_abs > dr_abs) ? dq_abs : dr_abs;
        if (ds_abs > dist_max)
        begin
            dist_max = ds_abs;
        end
    end

    assign data_next = sts.ids_ok ? {second_r, second_q, first_r, first_q,
                                     dist_max[DIST_W-1:0]}
                                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_data_reg <= data_next;
            out_user_reg <= sts.ids_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

@@ rtl/hid_ctrl.sv @@
// ----------------------------------------------------------------------------
// hid_ctrl
// sequencer for one transaction: capture, range check, column walk if the ids are in range, result
// ----------------------------------------------------------------------------
module hid_ctrl
    import hid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  hid_sts_t sts,
    output hid_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_CHECK;
                    in_ready_next = 1'b0;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.ids_ok ? ST_WALK : ST_FINISH;
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready        = in_ready_reg;
    assign cmd.capture     = in_valid && in_ready_reg;
    assign cmd.step        = (state_reg == ST_WALK);
    assign cmd.result_load = (state_reg == ST_FINISH) && sts.out_free;

endmodule

@@ rtl/hid_checker.sv @@
// ----------------------------------------------------------------------------
// hid_checker
// port-level checks for the hex grid id distance core, bound to the top level
// ----------------------------------------------------------------------------
module hid_checker
    import hid_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    logic signed [DIFF_W-1:0] dq;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] ds;
    logic [DIFF_W-1:0]        dq_abs;
    logic [DIFF_W-1:0]        dr_abs;
    logic [DIFF_W-1:0]        ds_abs;
    logic [DIFF_W-1:0]        dist_max;
    logic                     dist_ok;

    // distance recomputed from the coordinates shown on the output
    always_comb
    begin
        dq = DIFF_W'($signed(m_axis_tdata[15:8])) - DIFF_W'($signed(m_axis_tdata[31:24]));
        dr = DIFF_W'($signed(m_axis_tdata[23:16])) - DIFF_W'($signed(m_axis_tdata[39:32]));
        ds = dq + dr;
        dq_abs = dq[DIFF_W-1] ? DIFF_W'(-dq) : DIFF_W'(dq);
        dr_abs = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
        ds_abs = ds[DIFF_W-1] ? DIFF_W'(-ds) : DIFF_W'(ds);
        dist_max = (dq_abs > dr_abs) ? dq_abs : dr_abs;
        if (ds_abs > dist_max)
        begin
            dist_max = ds_abs;
        end
        dist_ok = (dist_max[DIST_W-1:0] == m_axis_tdata[DIST_W-1:0]);
    end

    // invalid ids give an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero payload on invalid ids");

    // a valid result carries the cube distance of its own coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> dist_ok)
        else $error("distance does not match coordinates");

    // the block is not ready in the cycle after it takes a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind hex_id_distance_core hid_checker u_hid_checker (.*);
